@@ rtl/qrs_pkg.sv @@
// Package: shared constants and root-kind codes for the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;
	localparam int FRACTION_BITS = 16;
	localparam int COEF_WIDTH    = 16;
	localparam int OUT_WIDTH     = 35;
	localparam int KIND_WIDTH    = 2;

	localparam logic [KIND_WIDTH-1:0] KIND_TWO_REAL   = 2'd0;
	localparam logic [KIND_WIDTH-1:0] KIND_DOUBLE     = 2'd1;
	localparam logic [KIND_WIDTH-1:0] KIND_COMPLEX    = 2'd2;
	localparam logic [KIND_WIDTH-1:0] KIND_DEGENERATE = 2'd3;
endpackage

@@ rtl/qrs_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per stage, with side data.
`timescale 1ns / 1ps
module qrs_sqrt_pipe #(
	parameter int P      = 33,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [2*P-1:0]    rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [P-1:0]      root,
	output logic [SIDE_W-1:0] out_side
);
	logic              vld_s  [0:P];
	logic [2*P-1:0]    rad_s  [0:P];
	logic [P+1:0]      rem_s  [0:P];
	logic [P-1:0]      root_s [0:P];
	logic [SIDE_W-1:0] side_s [0:P];

	assign vld_s[0]  = in_vld;
	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < P; i++) begin : g_stage
		logic [P+1:0] rem_nx;
		logic [P+1:0] trial;
		logic         ge;
		always_comb begin
			rem_nx = {rem_s[i][P-1:0], rad_s[i][2*P-1 -: 2]};
			trial  = {root_s[i], 2'b01};
			ge     = (rem_nx >= trial);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			rad_s[i+1]  <= {rad_s[i][2*P-3:0], 2'b00};
			rem_s[i+1]  <= ge ? (rem_nx - trial) : rem_nx;
			root_s[i+1] <= {root_s[i][P-2:0], ge};
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_vld  = vld_s[P];
	assign root     = root_s[P];
	assign out_side = side_s[P];
endmodule

@@ rtl/qrs_div_pipe.sv @@
// Pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage.
`timescale 1ns / 1ps
module qrs_div_pipe #(
	parameter int NW     = 34,
	parameter int DW     = 17,
	parameter int SIDE_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [NW-1:0]     num0,
	input  logic [NW-1:0]     num1,
	input  logic [DW-1:0]     den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [NW-1:0]     quo0,
	output logic [NW-1:0]     quo1,
	output logic [SIDE_W-1:0] out_side
);
	logic              vld_s  [0:NW];
	logic [NW-1:0]     n0_s   [0:NW];
	logic [NW-1:0]     n1_s   [0:NW];
	logic [DW:0]       r0_s   [0:NW];
	logic [DW:0]       r1_s   [0:NW];
	logic [NW-1:0]     q0_s   [0:NW];
	logic [NW-1:0]     q1_s   [0:NW];
	logic [DW-1:0]     d_s    [0:NW];
	logic [SIDE_W-1:0] side_s [0:NW];

	assign vld_s[0]  = in_vld;
	assign n0_s[0]   = num0;
	assign n1_s[0]   = num1;
	assign r0_s[0]   = '0;
	assign r1_s[0]   = '0;
	assign q0_s[0]   = '0;
	assign q1_s[0]   = '0;
	assign d_s[0]    = den;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0] t0, t1, dx;
		logic        ge0, ge1;
		always_comb begin
			dx  = {1'b0, d_s[i]};
			t0  = {r0_s[i][DW-1:0], n0_s[i][NW-1]};
			t1  = {r1_s[i][DW-1:0], n1_s[i][NW-1]};
			ge0 = (t0 >= dx);
			ge1 = (t1 >= dx);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			n0_s[i+1]   <= n0_s[i] << 1;
			n1_s[i+1]   <= n1_s[i] << 1;
			r0_s[i+1]   <= ge0 ? (t0 - dx) : t0;
			r1_s[i+1]   <= ge1 ? (t1 - dx) : t1;
			q0_s[i+1]   <= {q0_s[i][NW-2:0], ge0};
			q1_s[i+1]   <= {q1_s[i][NW-2:0], ge1};
			d_s[i+1]    <= d_s[i];
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_vld  = vld_s[NW];
	assign quo0     = q0_s[NW];
	assign quo1     = q1_s[NW];
	assign out_side = side_s[NW];
endmodule

@@ rtl/quadratic_root_solver_unit.sv @@
// Top level: pipelined quadratic root solver (discriminant, square root, divide).
`timescale 1ns / 1ps
//
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ---------------------------
// input     coef_a, coef_b, coef_c                  word taken when start && !busy
// result    root_kind, first_value, second_value    word valid for one cycle with done
//
// One word enters per cycle; busy is always low because nothing downstream can stall.
// The pipe holds P = COEF_WIDTH+FRACTION_BITS+1 square-root digit stages and NMW =
// COEF_WIDTH+FRACTION_BITS+2 divider quotient-bit stages between its other registers.
// The length comes from the digit-by-digit square root and the restoring divider pipes.
// Reset clears only the valid bits; payload registers carry no reset.
// The receiver cannot hold results off, so every word leaves exactly once, in order.
module quadratic_root_solver_unit #(
	parameter int FRACTION_BITS = qrs_pkg::FRACTION_BITS,
	parameter int COEF_WIDTH    = qrs_pkg::COEF_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [COEF_WIDTH-1:0]      coef_a,
	input  logic signed [COEF_WIDTH-1:0]      coef_b,
	input  logic signed [COEF_WIDTH-1:0]      coef_c,
	output logic                              done,
	output logic [qrs_pkg::KIND_WIDTH-1:0]    root_kind,
	output logic signed [qrs_pkg::OUT_WIDTH-1:0] first_value,
	output logic signed [qrs_pkg::OUT_WIDTH-1:0] second_value
);
	localparam int CW  = COEF_WIDTH;
	localparam int FB  = FRACTION_BITS;
	localparam int KW  = qrs_pkg::KIND_WIDTH;
	localparam int OW  = qrs_pkg::OUT_WIDTH;
	localparam int DSW = 2*CW + 2;           // signed discriminant
	localparam int MW  = 2*CW + 1;           // |discriminant|
	localparam int P   = CW + FB + 1;        // square-root digits / root width
	localparam int NMW = CW + FB + 2;        // numerator magnitude
	localparam int NSW = NMW + 1;            // signed numerator
	localparam int DW  = CW + 1;             // 2|a|
	localparam int EW  = (NSW > OW) ? NSW : OW;
	localparam int SQ_SIDE = KW + 2*CW;
	localparam int DV_SIDE = KW + 2;

	// Stage 1: capture coefficients.
	logic                 vld_s1;
	logic signed [CW-1:0] a_s1, b_s1, c_s1;

	// Stage 2: products.
	logic                   vld_s2;
	logic signed [CW-1:0]   a_s2, b_s2;
	logic signed [2*CW-1:0] bb_s2, ac_s2;

	// Stage 3: discriminant classified.
	logic                 vld_s3;
	logic [KW-1:0]        kind_s3;
	logic [MW-1:0]        dmag_s3;
	logic signed [CW-1:0] a_s3, b_s3;

	logic signed [DSW-1:0] disc;
	logic [KW-1:0]         kind_nx;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		a_s1  <= coef_a;
		b_s1  <= coef_b;
		c_s1  <= coef_c;
		a_s2  <= a_s1;
		b_s2  <= b_s1;
		bb_s2 <= b_s1 * b_s1;
		ac_s2 <= a_s1 * c_s1;
	end

	// Discriminant b*b - 4ac; classify by sign, degenerate when a is zero.
	always_comb begin
		disc = DSW'(bb_s2) - (DSW'(ac_s2) <<< 2);
		if (a_s2 == '0) begin
			kind_nx = qrs_pkg::KIND_DEGENERATE;
		end else if (disc[DSW-1]) begin
			kind_nx = qrs_pkg::KIND_COMPLEX;
		end else if (disc == '0) begin
			kind_nx = qrs_pkg::KIND_DOUBLE;
		end else begin
			kind_nx = qrs_pkg::KIND_TWO_REAL;
		end
	end

	always_ff @(posedge clk) begin
		kind_s3 <= kind_nx;
		dmag_s3 <= disc[DSW-1] ? MW'(-disc) : MW'(disc);
		a_s3    <= a_s2;
		b_s3    <= b_s2;
	end

	// Square root of |D| * 2^(2*FB), so the root carries FB fraction bits.
	logic               sq_vld;
	logic [P-1:0]       sq_root;
	logic [SQ_SIDE-1:0] sq_side;

	qrs_sqrt_pipe #(.P(P), .SIDE_W(SQ_SIDE)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.rad      ({1'b0, dmag_s3, {(2*FB){1'b0}}}),
		.in_side  ({kind_s3, a_s3, b_s3}),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_side (sq_side)
	);

	// Stage 4: form numerators, split into sign and magnitude.
	logic [KW-1:0]         sq_kind;
	logic signed [CW-1:0]  sq_a, sq_b;
	logic signed [NSW-1:0] negb, sval, n0, n1;

	always_comb begin
		sq_kind = sq_side[SQ_SIDE-1 -: KW];
		sq_a    = sq_side[2*CW-1 -: CW];
		sq_b    = sq_side[CW-1:0];
		negb    = -(NSW'(sq_b) <<< FB);
		sval    = NSW'({1'b0, sq_root});
		n0      = negb;
		n1      = negb;
		case (sq_kind)
			qrs_pkg::KIND_TWO_REAL: begin
				n0 = negb + sval;
				n1 = negb - sval;
			end
			qrs_pkg::KIND_COMPLEX: begin
				n1 = sval;
			end
			default: begin
			end
		endcase
	end

	logic              vld_s4;
	logic [NMW-1:0]    n0_s4, n1_s4;
	logic [DW-1:0]     den_s4;
	logic [KW-1:0]     kind_s4;
	logic              neg0_s4, neg1_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= sq_vld;
		end
	end

	// Quotient sign: numerator sign xor sign of a; the imaginary part, also divided by 2|a|, keeps the numerator sign.
	always_ff @(posedge clk) begin
		n0_s4   <= n0[NSW-1] ? NMW'(-n0) : NMW'(n0);
		n1_s4   <= n1[NSW-1] ? NMW'(-n1) : NMW'(n1);
		den_s4  <= sq_a[CW-1] ? ((-DW'(sq_a)) << 1) : (DW'(sq_a) << 1);
		kind_s4 <= sq_kind;
		neg0_s4 <= n0[NSW-1] ^ sq_a[CW-1];
		neg1_s4 <= n1[NSW-1] ^ (sq_a[CW-1] && (sq_kind != qrs_pkg::KIND_COMPLEX));
	end

	logic               dv_vld;
	logic [NMW-1:0]     q0, q1;
	logic [DV_SIDE-1:0] dv_side;

	qrs_div_pipe #(.NW(NMW), .DW(DW), .SIDE_W(DV_SIDE)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.num0     (n0_s4),
		.num1     (n1_s4),
		.den      (den_s4),
		.in_side  ({kind_s4, neg0_s4, neg1_s4}),
		.out_vld  (dv_vld),
		.quo0     (q0),
		.quo1     (q1),
		.out_side (dv_side)
	);

	// Output: restore sign, saturate to the result width, zero for degenerate.
	localparam logic signed [EW-1:0] SAT_HI = (EW'(1) <<< (OW-1)) - EW'(1);
	localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

	logic [KW-1:0]        dv_kind;
	logic signed [EW-1:0] e0, e1, c0, c1;

	always_comb begin
		dv_kind = dv_side[DV_SIDE-1 -: KW];
		e0 = dv_side[1] ? -EW'(q0) : EW'(q0);
		e1 = dv_side[0] ? -EW'(q1) : EW'(q1);
		c0 = (e0 > SAT_HI) ? SAT_HI : ((e0 < SAT_LO) ? SAT_LO : e0);
		c1 = (e1 > SAT_HI) ? SAT_HI : ((e1 < SAT_LO) ? SAT_LO : e1);
		if (dv_kind == qrs_pkg::KIND_DEGENERATE) begin
			c0 = '0;
			c1 = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		root_kind    <= dv_kind;
		first_value  <= OW'(c0);
		second_value <= OW'(c1);
	end

`ifndef SYNTHESIS
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && root_kind == qrs_pkg::KIND_DEGENERATE |->
		first_value == '0 && second_value == '0)
		else $error("degenerate result not zero");

	a_double_equal: assert property (@(posedge clk) disable iff (!arst_n)
		done && root_kind == qrs_pkg::KIND_DOUBLE |-> first_value == second_value)
		else $error("double root halves differ");

	a_imag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		done && root_kind == qrs_pkg::KIND_COMPLEX |-> !second_value[OW-1])
		else $error("imaginary magnitude negative");
`endif
endmodule
